@@ src/wsd_pkg.sv @@
// ----------------------------------------------------------------------------
// wsd_pkg
// Shared types and constants for the work-stealing deque.
// ----------------------------------------------------------------------------
package wsd_pkg;

    // default geometry
    localparam int unsigned SLOT_BITS_DEF  = 10;
    localparam int unsigned ITEM_WIDTH_DEF = 64;

    // fixed field widths on the stream ports
    localparam int unsigned WORD_W  = 64;
    localparam int unsigned OP_W    = 2;
    localparam int unsigned OCC_W   = 11;
    localparam int unsigned S_DATA_W = 64;
    localparam int unsigned M_DATA_W = 80;   // 64 + 11, padded to whole bytes
    localparam int unsigned M_USER_W = 2;

    // operation codes
    localparam logic [OP_W-1:0] OP_PUSH  = 2'd0;
    localparam logic [OP_W-1:0] OP_POP   = 2'd1;
    localparam logic [OP_W-1:0] OP_STEAL = 2'd2;

    // per-operation status handed from index control to the datapath
    typedef struct packed {
        logic write;     // store the pushed word
        logic take;      // a word is read out (pop or steal hit)
        logic overflow;  // push dropped, deque full
    } wsd_flags_t;

endpackage

@@ src/wsd_ram.sv @@
// ----------------------------------------------------------------------------
// wsd_ram
// Generic single-port synchronous RAM, registered read, read-first.
// ----------------------------------------------------------------------------
module wsd_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

@@ src/wsd_ctrl.sv @@
// ----------------------------------------------------------------------------
// wsd_ctrl
// Top and bottom index registers; decodes one operation into a store access.
// ----------------------------------------------------------------------------
module wsd_ctrl #(
    parameter int unsigned SLOT_BITS = 10
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            op_accept,
    input  logic [wsd_pkg::OP_W-1:0]        op,
    output logic [SLOT_BITS-1:0]            addr,
    output wsd_pkg::wsd_flags_t             flags,
    output logic [SLOT_BITS:0]              count_next
);
    import wsd_pkg::*;

    localparam int unsigned IDX_W = SLOT_BITS + 1;

    logic [IDX_W-1:0] top_reg, top_next;
    logic [IDX_W-1:0] bottom_reg, bottom_next;
    logic [IDX_W-1:0] count;
    logic [IDX_W-1:0] bottom_dec;
    logic [IDX_W-1:0] top_inc;
    logic             full;
    logic             empty;

    assign count      = bottom_reg - top_reg;
    assign full       = count[SLOT_BITS];
    assign empty      = (count == '0);
    assign bottom_dec = bottom_reg - IDX_W'(1);
    assign top_inc    = top_reg + IDX_W'(1);

    always_comb begin
        top_next    = top_reg;
        bottom_next = bottom_reg;
        addr        = bottom_reg[SLOT_BITS-1:0];
        flags       = '0;
        unique case (op)
            OP_PUSH: begin
                if (full) begin
                    flags.overflow = 1'b1;
                end else begin
                    flags.write = 1'b1;
                    bottom_next = bottom_reg + IDX_W'(1);
                end
            end
            OP_POP: begin
                addr = bottom_dec[SLOT_BITS-1:0];
                if (!empty) begin
                    flags.take = 1'b1;
                    // last word: both ends settle one past the old top
                    if (count == IDX_W'(1)) begin
                        top_next    = top_inc;
                        bottom_next = top_inc;
                    end else begin
                        bottom_next = bottom_dec;
                    end
                end
            end
            OP_STEAL: begin
                addr = top_reg[SLOT_BITS-1:0];
                if (!empty) begin
                    flags.take = 1'b1;
                    top_next   = top_inc;
                end
            end
            default: begin
            end
        endcase
    end

    assign count_next = bottom_next - top_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            top_reg    <= '0;
            bottom_reg <= '0;
        end else if (op_accept) begin
            top_reg    <= top_next;
            bottom_reg <= bottom_next;
        end
    end

endmodule

@@ src/work_stealing_deque.sv @@
// Path: an accepted input word is registered by the store read, then by the
// output register that drives m_tvalid.
// Flow: no new word is taken while the read of the item store is pending,
// so operations do not overlap.
// Reset: synchronous on aresetn low; clears top and bottom indices and the
// handshake state. The item store is not cleared.
// ----------------------------------------------------------------------------
// work_stealing_deque
// Work-stealing deque: push/pop at the bottom, steal at the top, held in a
// ring store with fixed capacity.
// ----------------------------------------------------------------------------
module work_stealing_deque #(
    parameter int unsigned SLOT_BITS  = wsd_pkg::SLOT_BITS_DEF,
    parameter int unsigned ITEM_WIDTH = wsd_pkg::ITEM_WIDTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [wsd_pkg::S_DATA_W-1:0]  s_tdata,   // [63:0] work_word
    input  logic [wsd_pkg::OP_W-1:0]      s_tuser,   // [1:0] operation
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [wsd_pkg::M_DATA_W-1:0]  m_tdata,   // [63:0] result_word, [74:64] occupancy
    output logic [wsd_pkg::M_USER_W-1:0]  m_tuser    // [0] found, [1] overflow
);
    import wsd_pkg::*;

    localparam int unsigned DEPTH = 1 << SLOT_BITS;

    logic                     s_accept;
    logic [SLOT_BITS-1:0]     ram_addr;
    wsd_flags_t               flags;
    logic [SLOT_BITS:0]       count_next;
    logic [ITEM_WIDTH-1:0]    ram_rdata;

    // read stage
    logic                     pend_reg;
    wsd_flags_t               pend_flags_reg;
    logic [SLOT_BITS:0]       pend_count_reg;

    // output register
    logic                     out_valid_reg;
    logic [WORD_W-1:0]        out_word_reg;
    logic                     out_found_reg;
    logic                     out_overflow_reg;
    logic [OCC_W-1:0]         out_occ_reg;

    assign s_tready = !pend_reg && (!out_valid_reg || m_tready);
    assign s_accept = s_tvalid && s_tready;

    wsd_ctrl #(
        .SLOT_BITS (SLOT_BITS)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .op_accept  (s_accept),
        .op         (s_tuser),
        .addr       (ram_addr),
        .flags      (flags),
        .count_next (count_next)
    );

    wsd_ram #(
        .WIDTH (ITEM_WIDTH),
        .DEPTH (DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (s_accept && flags.write),
        .addr  (ram_addr),
        .wdata (s_tdata[ITEM_WIDTH-1:0]),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= 1'b0;
        end else begin
            pend_reg <= s_accept;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            pend_flags_reg <= flags;
            pend_count_reg <= count_next;
        end
    end

    // output register is always free when the read stage completes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (pend_reg) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (pend_reg) begin
            out_word_reg     <= pend_flags_reg.take ? WORD_W'(ram_rdata) : '0;
            out_found_reg    <= pend_flags_reg.take;
            out_overflow_reg <= pend_flags_reg.overflow;
            out_occ_reg      <= OCC_W'(pend_count_reg);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_DATA_W - WORD_W - OCC_W){1'b0}}, out_occ_reg, out_word_reg};
    assign m_tuser  = {out_overflow_reg, out_found_reg};

endmodule

@@ src/wsd_checker.sv @@
// ----------------------------------------------------------------------------
// wsd_checker
// Port-level checks on the work-stealing deque, bound to the top level.
// ----------------------------------------------------------------------------
module wsd_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [wsd_pkg::M_DATA_W-1:0]  m_tdata,
    input logic [wsd_pkg::M_USER_W-1:0]  m_tuser
);

    // every accepted word yields a result after the read stage and the output register
    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> ##1 m_tvalid)
        else $error("no result after accepted word");

    // one operation in flight at a time
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while a read is pending");

    // a miss or a push carries a zero word
    a_zero_on_miss: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata[63:0] == 64'd0)
        else $error("nonzero word without found");

    a_found_xor_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
        else $error("found and overflow both set");

    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

endmodule

bind work_stealing_deque wsd_checker u_wsd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

@@ verif/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for work_stealing_deque. Operations are streamed in
// through the s_ channel, a shadow deque predicts each result, and the
// results on the m_ channel are compared in order. The stimulus fills the
// deque past full, then runs a mixed stretch near full.
// ----------------------------------------------------------------------------
module tb;
    import wsd_pkg::*;

    localparam int unsigned LOG_CAP        = SLOT_BITS_DEF;
    localparam int unsigned CAP            = 1 << LOG_CAP;
    localparam int unsigned IDX_W          = LOG_CAP + 1;
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned HOLD_START     = 1000;
    localparam int unsigned HOLD_LEN       = 200;
    localparam int unsigned QUIET_TAIL     = 150;
    localparam int unsigned MAX_REPORTS    = 10;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [WORD_W-1:0] word;
    } deque_op_t;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              found;
        logic              overflow;
        logic [OCC_W-1:0]  occ;
    } deque_result_t;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;   // [63:0] work_word
    logic [OP_W-1:0]     s_tuser  = OP_PUSH;  // [1:0] operation
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;         // [63:0] result_word, [74:64] occupancy
    logic [M_USER_W-1:0] m_tuser;         // [0] found, [1] overflow

    deque_op_t         pending_ops[$];
    deque_result_t     expected_results[$];

    // shadow deque
    logic [WORD_W-1:0] shadow_store [CAP];
    logic [IDX_W-1:0]  shadow_top = '0;
    logic [IDX_W-1:0]  shadow_bot = '0;

    int unsigned       mismatch_cnt  = 0;
    int unsigned       gen_held      = 0;
    int unsigned       gen_overflows = 0;
    logic              quiet_tail    = 1'b0;

    work_stealing_deque dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    function automatic deque_result_t apply_deque_op(logic [OP_W-1:0] op,
                                                     logic [WORD_W-1:0] word);
        deque_result_t    r;
        logic [IDX_W-1:0] held;
        logic [IDX_W-1:0] last;
        r    = '0;
        held = shadow_bot - shadow_top;
        last = shadow_bot - 1'b1;
        case (op)
            OP_PUSH: begin
                if (held >= CAP) begin
                    r.overflow = 1'b1;
                end else begin
                    shadow_store[shadow_bot[LOG_CAP-1:0]] = word;
                    shadow_bot = shadow_bot + 1'b1;
                end
            end
            OP_POP: begin
                if (held != 0) begin
                    r.word  = shadow_store[last[LOG_CAP-1:0]];
                    r.found = 1'b1;
                    // taking the last word parks both indices one past old top
                    if (held == 1) begin
                        shadow_top = shadow_top + 1'b1;
                        shadow_bot = shadow_top;
                    end else begin
                        shadow_bot = last;
                    end
                end
            end
            OP_STEAL: begin
                if (held != 0) begin
                    r.word     = shadow_store[shadow_top[LOG_CAP-1:0]];
                    r.found    = 1'b1;
                    shadow_top = shadow_top + 1'b1;
                end
            end
            default: begin
            end
        endcase
        r.occ = shadow_bot - shadow_top;
        return r;
    endfunction

    function automatic logic [WORD_W-1:0] rand_word();
        int unsigned pick;
        pick = $urandom_range(0, 15);
        if (pick == 0) return '0;
        if (pick == 1) return '1;
        return {$urandom, $urandom};
    endfunction

    task automatic queue_op(input logic [OP_W-1:0] op, input logic [WORD_W-1:0] word);
        deque_op_t it;
        it.op   = op;
        it.word = word;
        pending_ops.push_back(it);
        if (op == OP_PUSH && gen_held < CAP) gen_held++;
        else if (op != OP_PUSH && gen_held > 0) gen_held--;
        else if (op == OP_PUSH) gen_overflows++;
    endtask

    // sender
    int unsigned send_gap     = 0;
    bit          send_idle_on = 1'b1;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_results.push_back(apply_deque_op(s_tuser, s_tdata));
                void'(pending_ops.pop_front());
            end
            quiet_tail <= (pending_ops.size() <= QUIET_TAIL);
            if ($urandom_range(0, 127) == 0) send_idle_on = !send_idle_on;
            // a word on offer stays put until taken
            if (!s_tvalid || s_tready) begin
                if (send_gap != 0) begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end else if (pending_ops.size() == 0) begin
                    s_tvalid <= 1'b0;
                end else if (!quiet_tail && send_idle_on && $urandom_range(0, 5) == 0) begin
                    send_gap = $urandom_range(0, 3);
                    s_tvalid <= 1'b0;
                end else begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= pending_ops[0].word;
                    s_tuser  <= pending_ops[0].op;
                end
            end
        end
    end

    // receiver: short random stalls plus one long hold-off to back up the block
    int unsigned rx_cycle     = 0;
    int unsigned rx_gap       = 0;
    int unsigned hold_left    = 0;
    bit          recv_idle_on = 1'b1;
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            rx_cycle++;
            if ($urandom_range(0, 127) == 0) recv_idle_on = !recv_idle_on;
            if (rx_cycle == HOLD_START) hold_left = HOLD_LEN;
            if (hold_left != 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (rx_gap != 0) begin
                rx_gap--;
                m_tready <= 1'b0;
            end else if (!quiet_tail && recv_idle_on && $urandom_range(0, 4) == 0) begin
                rx_gap = $urandom_range(0, 3);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // result checker
    always @(posedge aclk) begin
        deque_result_t got;
        deque_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.word     = m_tdata[WORD_W-1:0];
            got.occ      = m_tdata[WORD_W +: OCC_W];
            got.found    = m_tuser[0];
            got.overflow = m_tuser[1];
            if (expected_results.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= MAX_REPORTS)
                    $display("unexpected result word: word %h found %b overflow %b occ %0d",
                             got.word, got.found, got.overflow, got.occ);
            end else begin
                want = expected_results.pop_front();
                if (got !== want) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= MAX_REPORTS)
                        $display({"mismatch: exp word %h found %b overflow %b occ %0d",
                                  " / got word %h found %b overflow %b occ %0d"},
                                 want.word, want.found, want.overflow, want.occ,
                                 got.word, got.found, got.overflow, got.occ);
                end
            end
        end
    end

    // watchdog on cycles with no word moving on either side
    int unsigned stall_cycles = 0;
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("[work_stealing_deque] ERROR");
            $finish;
        end
    end

    initial begin
        int unsigned pick;

        // directed: empty ends, word extremes, both take paths, last-word cases
        queue_op(OP_STEAL, '1);
        queue_op(OP_POP, '1);
        queue_op(OP_PUSH, '0);
        queue_op(OP_PUSH, '1);
        queue_op(OP_PUSH, {32{2'b10}});
        queue_op(OP_PUSH, {32{2'b01}});
        queue_op(OP_POP, '0);
        queue_op(OP_STEAL, '0);
        queue_op(OP_STEAL, '0);
        queue_op(OP_POP, '0);        // last word taken from the bottom
        queue_op(OP_POP, '0);
        queue_op(OP_PUSH, 64'h8000_0000_0000_0001);
        queue_op(OP_STEAL, '0);      // last word taken from the top
        queue_op(OP_STEAL, '0);
        queue_op(OP_PUSH, rand_word());
        queue_op(OP_PUSH, rand_word());
        queue_op(OP_POP, '0);
        queue_op(OP_POP, '0);
        queue_op(OP_PUSH, rand_word());
        queue_op(OP_STEAL, rand_word());

        // fill past full so pushes get dropped
        while (gen_held < CAP || gen_overflows < 12) begin
            pick = $urandom_range(0, 99);
            if (pick < 98) queue_op(OP_PUSH, rand_word());
            else if (pick < 99) queue_op(OP_POP, rand_word());
            else queue_op(OP_STEAL, rand_word());
        end

        // mixed traffic around full: takes from both ends, dropped pushes
        repeat (150) begin
            pick = $urandom_range(0, 2);
            case (pick)
                0: queue_op(OP_PUSH, rand_word());
                1: queue_op(OP_POP, rand_word());
                default: queue_op(OP_STEAL, rand_word());
            endcase
        end

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        do @(posedge aclk); while (pending_ops.size() != 0 || expected_results.size() != 0);
        repeat (20) @(posedge aclk);
        if (mismatch_cnt == 0)
            $display("[work_stealing_deque] OK");
        else
            $display("[work_stealing_deque] ERROR");
        $finish;
    end

endmodule
